// ===== rtl/core/wls_pkg.sv =====
// ----------------------------------------------------------------------------
// wls_pkg
// shared types and constants for the windowed latency statistics block
// ----------------------------------------------------------------------------
package wls_pkg;

  localparam int WINDOW_DEF = 100;
  localparam int LAT_W      = 16;
  localparam int CNT_W      = 32;
  localparam int MEAN_W     = 24;
  localparam int LOSS_W     = 14;
  localparam int FILL_W     = 7;
  localparam int LOSS_SCALE = 10000;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // control handed along the chain
  typedef struct packed {
    logic load;   // push a new latency into the first cell
    logic clear;  // drop every cell
  } wls_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV_MEAN,
    ST_DIV_LOSS,
    ST_OUT
  } wls_state_t;

endpackage

// ===== rtl/core/wls_cell.sv =====
// ----------------------------------------------------------------------------
// wls_cell
// one window slot: holds a latency and a valid flag, shifts to its neighbor;
// the min and max compare moves one cell per cycle
// ----------------------------------------------------------------------------
module wls_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  wls_pkg::wls_ctl_t             ctl,
  input  logic [wls_pkg::LAT_W-1:0]     prev_val,
  input  logic                          prev_vld,
  input  logic [wls_pkg::LAT_W-1:0]     min_in,
  input  logic [wls_pkg::LAT_W-1:0]     max_in,
  output logic [wls_pkg::LAT_W-1:0]     val,
  output logic                          vld,
  output logic [wls_pkg::LAT_W-1:0]     min_out,
  output logic [wls_pkg::LAT_W-1:0]     max_out
);
  import wls_pkg::*;

  // slot storage, shifts on load
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      vld <= 1'b0;
    end else if (ctl.load) begin
      vld <= prev_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      val <= prev_val;
    end
  end

  // running min and max step of this cell, registered toward the next cell
  always_ff @(posedge clk) begin
    min_out <= (vld && val < min_in) ? val : min_in;
    max_out <= (vld && val > max_in) ? val : max_in;
  end
endmodule

// ===== rtl/core/wls_div.sv =====
// ----------------------------------------------------------------------------
// wls_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wls_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  import wls_pkg::*;

  localparam int CW = $clog2(NUM_W + 1);

  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] dreg;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DEN_W:0]   trial;

  assign trial = {rem[DEN_W-1:0], quo[NUM_W-1]};

  // shift, compare and subtract per step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= num;
      dreg <= den;
    end else if (busy) begin
      if (trial >= {1'b0, dreg}) begin
        rem <= trial - {1'b0, dreg};
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end
endmodule

// ===== rtl/core/windowed_latency_statistics.sv =====
// ----------------------------------------------------------------------------
// windowed_latency_statistics
// probe counters, sliding latency window with min, max, mean and loss ratio
// ----------------------------------------------------------------------------
// sequence: a clear item gives its result in the cycle after accept; a failed probe
//   waits for the 48-bit loss divide; a success runs the pipelined cell scan, then
//   the mean divide, then the loss divide
// throughput: one item at a time, the next item is taken after the result leaves
// reset: rst synchronous active high clears counters, window and outputs
module windowed_latency_statistics #(
  parameter int WINDOW = wls_pkg::WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [0:0]  s_tuser,   // op
  input  logic [23:0] s_tdata,   // success, latency, zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  // sent_count, received_count, lost_count, current_latency, min_latency,
  // max_latency, mean_latency_q8, loss (hundredths of a percent), window_fill, zero pad
  output logic [199:0] m_tdata
);
  import wls_pkg::*;

  localparam int SW = LAT_W + $clog2(WINDOW + 1);
  localparam int FW = $clog2(WINDOW + 1);
  localparam int SC = $clog2(WINDOW + 2);

  wls_state_t state, state_next;

  logic [CNT_W-1:0]  sent, recv, lost;
  logic [LAT_W-1:0]  last_lat, wmin, wmax;
  logic [MEAN_W-1:0] wmean;
  logic [LOSS_W-1:0] loss;
  logic [FW-1:0]     fill;
  logic [SW-1:0]     wsum;
  logic [LAT_W-1:0]  pend_lat;
  logic [SC-1:0]     scan_cnt;
  logic              ldiv_pend;

  wls_ctl_t ctl;
  logic [LAT_W-1:0] cval [WINDOW];
  logic             cvld [WINDOW];
  logic [LAT_W-1:0] cmin [WINDOW+1];
  logic [LAT_W-1:0] cmax [WINDOW+1];

  logic accept;
  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE) && !m_tvalid;

  // cell chain: newest at cell 0, oldest drops off the end
  assign cmin[0] = '1;
  assign cmax[0] = '0;
  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    wls_cell u_cell (
      .clk(clk), .rst(rst), .ctl(ctl),
      .prev_val((g == 0) ? pend_lat : cval[(g == 0) ? 0 : g-1]),
      .prev_vld((g == 0) ? 1'b1 : cvld[(g == 0) ? 0 : g-1]),
      .min_in(cmin[g]), .max_in(cmax[g]),
      .val(cval[g]), .vld(cvld[g]),
      .min_out(cmin[g+1]), .max_out(cmax[g+1])
    );
  end

  // oldest entry leaving when full
  logic [LAT_W-1:0] oldest;
  assign oldest = cvld[WINDOW-1] ? cval[WINDOW-1] : '0;

  // dividers
  localparam int MN_W = SW + 8;
  logic mdiv_start, mdiv_done, ldiv_start, ldiv_done;
  logic [MN_W-1:0] mquo;
  logic [47:0]     lquo;
  wls_div #(.NUM_W(MN_W), .DEN_W(FW)) u_mdiv (
    .clk(clk), .rst(rst), .start(mdiv_start), .num({wsum, 8'd0}), .den(fill),
    .done(mdiv_done), .quo(mquo)
  );
  logic [47:0] lnum;
  assign lnum = 48'(lost) * 48'(LOSS_SCALE);
  wls_div #(.NUM_W(48), .DEN_W(CNT_W)) u_ldiv (
    .clk(clk), .rst(rst), .start(ldiv_start), .num(lnum), .den(sent),
    .done(ldiv_done), .quo(lquo)
  );

  // control sequencing
  always_comb begin
    state_next = state;
    ctl        = '0;
    mdiv_start = 1'b0;
    ldiv_start = 1'b0;
    case (state)
      ST_IDLE: if (accept) begin
        if (s_tuser[0] == OP_CLEAR) begin
          ctl.clear  = 1'b1;
          state_next = ST_OUT;
        end else if (s_tdata[0]) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_DIV_LOSS;
        end
      end
      ST_SCAN: if (scan_cnt == SC'(WINDOW + 1)) begin
        mdiv_start = 1'b1;
        state_next = ST_DIV_MEAN;
      end
      ST_DIV_MEAN: if (mdiv_done) state_next = ST_DIV_LOSS;
      ST_DIV_LOSS: if (ldiv_done) state_next = ST_OUT;
      ST_OUT: ;
      default: state_next = ST_IDLE;
    endcase
    if (state == ST_SCAN && scan_cnt == '0) ctl.load = 1'b1;
    if (state == ST_DIV_LOSS && !ldiv_pend) ldiv_start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) ldiv_pend <= 1'b0;
    else if (state != ST_DIV_LOSS) ldiv_pend <= 1'b0;
    else ldiv_pend <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else if (state == ST_OUT) state <= ST_IDLE;
    else state <= state_next;
  end

  // counters and window bookkeeping
  always_ff @(posedge clk) begin
    if (rst || (accept && s_tuser[0] == OP_CLEAR)) begin
      sent <= '0; recv <= '0; lost <= '0; last_lat <= '0;
      wmin <= '0; wmax <= '0; wmean <= '0; fill <= '0; wsum <= '0;
      scan_cnt <= '0; m_tvalid <= rst ? 1'b0 : 1'b1; loss <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (accept) begin
        pend_lat <= s_tdata[16:1];
        last_lat <= s_tdata[16:1];
        scan_cnt <= '0;
        if (sent != '1) sent <= sent + CNT_W'(1);
        if (s_tdata[0]) begin
          if (recv != '1) recv <= recv + CNT_W'(1);
        end else if (lost != '1) begin
          lost <= lost + CNT_W'(1);
        end
      end
      if (state == ST_SCAN) begin
        scan_cnt <= scan_cnt + SC'(1);
        if (scan_cnt == '0) begin
          if (fill == FW'(WINDOW)) wsum <= wsum - SW'(oldest) + SW'(pend_lat);
          else begin
            wsum <= wsum + SW'(pend_lat);
            fill <= fill + FW'(1);
          end
        end
        // min and max have rippled through every cell
        if (scan_cnt == SC'(WINDOW + 1)) begin
          wmin <= cmin[WINDOW];
          wmax <= cmax[WINDOW];
        end
      end
      if (mdiv_done) wmean <= mquo[MEAN_W-1:0];
      if (ldiv_done) begin
        loss     <= (sent == '0) ? '0 : lquo[LOSS_W-1:0];
        m_tvalid <= 1'b1;
      end
    end
  end

  assign m_tdata = {11'd0, FILL_W'(fill), loss, wmean, wmax, wmin, last_lat, lost, recv, sent};

  // checks
  assert property (@(posedge clk) disable iff (rst) (lost <= sent))
    else $error("lost exceeds sent");
  assert property (@(posedge clk) disable iff (rst) (fill <= FW'(WINDOW)))
    else $error("window fill overflow");
  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !s_tready)
    else $error("input taken while result pending");
endmodule

// ===== tb/windowed_latency_statistics_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_latency_statistics_tb
// drives probe outcomes and clear commands into the block and checks every
// statistics snapshot against a cycle-free predictor kept in the testbench
// ----------------------------------------------------------------------------
module windowed_latency_statistics_tb;
  import wls_pkg::*;

  localparam int WIN      = WINDOW_DEF;
  localparam int WDOG_MAX = 20000;

  typedef struct {
    logic        op;
    logic        success;
    logic [15:0] latency;
  } probe_t;

  typedef struct packed {
    logic [31:0] sent;
    logic [31:0] received;
    logic [31:0] lost;
    logic [15:0] current;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [23:0] mean;
    logic [13:0] loss;
    logic [6:0]  fill;
  } snapshot_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [0:0]   s_tuser;
  logic [23:0]  s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [199:0] m_tdata;

  // predictor state
  logic [15:0] ring [WIN];
  int unsigned wr_ptr, fill_cnt;
  logic [31:0] lat_sum;
  snapshot_t   stats;

  probe_t    pending_probes[$];
  snapshot_t expected_snaps[$];
  int        mismatches, wdog, items_sent, snaps_seen, clears_sent;
  int        src_wait, sink_wait;
  bit        hold_src;
  bit        in_fire, out_fire;

  windowed_latency_statistics u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] sat_up(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic void clear_stats();
    wr_ptr = 0;
    fill_cnt = 0;
    lat_sum = '0;
    stats = '0;
  endfunction

  // advance the statistics by one item and queue the resulting snapshot
  function automatic void predict_stats(probe_t p);
    logic [15:0] lo, hi;
    logic [63:0] wide;
    if (p.op == OP_CLEAR) begin
      clear_stats();
    end else begin
      stats.sent = sat_up(stats.sent);
      stats.current = p.latency;
      if (p.success) begin
        stats.received = sat_up(stats.received);
        if (fill_cnt >= WIN) lat_sum = lat_sum - ring[wr_ptr];
        else fill_cnt++;
        ring[wr_ptr] = p.latency;
        lat_sum = lat_sum + p.latency;
        wr_ptr = (wr_ptr + 1 >= WIN) ? 0 : wr_ptr + 1;
        lo = 16'hFFFF;
        hi = 16'h0;
        for (int i = 0; i < fill_cnt; i++) begin
          if (ring[i] < lo) lo = ring[i];
          if (ring[i] > hi) hi = ring[i];
        end
        stats.lo = lo;
        stats.hi = hi;
        wide = ({32'd0, lat_sum} << 8) / fill_cnt;
        stats.mean = wide[23:0];
      end else begin
        stats.lost = sat_up(stats.lost);
      end
    end
    if (stats.sent != 0) begin
      wide = (64'(stats.lost) * 64'd10000) / 64'(stats.sent);
      stats.loss = wide[13:0];
    end else begin
      stats.loss = '0;
    end
    stats.fill = fill_cnt[6:0];
    expected_snaps = {expected_snaps, stats};
  endfunction

  function automatic probe_t mk(logic op, logic ok, logic [15:0] lat);
    probe_t p;
    p.op = op;
    p.success = ok;
    p.latency = lat;
    return p;
  endfunction

  function automatic void queue_probe(logic op, logic ok, logic [15:0] lat);
    pending_probes = {pending_probes, mk(op, ok, lat)};
  endfunction

  // remember handshakes for the falling-edge blocks
  always @(posedge clk) begin
    if (rst) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire  <= s_tvalid && s_tready;
      out_fire <= m_tvalid && m_tready;
    end
  end

  // driver: one item per handshake, random gap after each
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_wait <= 0;
    end else if (s_tvalid && !in_fire) begin
      // hold the item
    end else if (src_wait > 0) begin
      s_tvalid <= 1'b0;
      src_wait <= src_wait - 1;
    end else if (pending_probes.size() > 0 && !hold_src) begin
      s_tvalid <= 1'b1;
      s_tuser  <= pending_probes[0].op;
      s_tdata  <= {7'd0, pending_probes[0].latency, pending_probes[0].success};
      void'(pending_probes.pop_front());
      src_wait <= $urandom_range(0, 3);
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // sink ready with random stalls after each item
  always @(negedge clk) begin
    int w;
    if (rst) begin
      m_tready <= 1'b0;
      sink_wait <= 0;
    end else if (out_fire) begin
      w = $urandom_range(0, 3);
      m_tready <= (w == 0);
      sink_wait <= (w == 0) ? 0 : w - 1;
    end else if (sink_wait > 0) begin
      m_tready <= 1'b0;
      sink_wait <= sink_wait - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor: predict on input accept, compare on output accept
  always @(posedge clk) begin
    snapshot_t got, want;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) wdog <= 0;
      else wdog <= wdog + 1;
      if (s_tvalid && s_tready) begin
        predict_stats(mk(s_tuser[0], s_tdata[0], s_tdata[16:1]));
        items_sent <= items_sent + 1;
        if (s_tuser[0] == OP_CLEAR) clears_sent <= clears_sent + 1;
      end
      if (m_tvalid && m_tready) begin
        snaps_seen <= snaps_seen + 1;
        got.sent     = m_tdata[31:0];
        got.received = m_tdata[63:32];
        got.lost     = m_tdata[95:64];
        got.current  = m_tdata[111:96];
        got.lo       = m_tdata[127:112];
        got.hi       = m_tdata[143:128];
        got.mean     = m_tdata[167:144];
        got.loss     = m_tdata[181:168];
        got.fill     = m_tdata[188:182];
        if (expected_snaps.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("unexpected snapshot %h", m_tdata);
        end else begin
          want = expected_snaps.pop_front();
          if (got != want) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("snapshot mismatch: exp %p got %p", want, got);
          end
        end
      end
      if (wdog >= WDOG_MAX) begin
        $display("timeout waiting for handshake");
        $display("windowed_latency_statistics_tb failed");
        $finish;
      end
    end
  end

  initial begin
    int n;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = '0;
    s_tdata = '0;
    m_tready = 1'b0;
    hold_src = 1'b0;
    mismatches = 0;
    wdog = 0;
    items_sent = 0;
    snaps_seen = 0;
    clears_sent = 0;
    clear_stats();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty stats, failures before success, extremes, clear
    queue_probe(OP_RECORD, 1'b0, 16'hFFFF);
    queue_probe(OP_RECORD, 1'b1, 16'h0000);
    queue_probe(OP_RECORD, 1'b1, 16'hFFFF);
    queue_probe(OP_RECORD, 1'b0, 16'h1234);
    queue_probe(OP_CLEAR, 1'b1, 16'hFFFF);
    queue_probe(OP_CLEAR, 1'b0, 16'h0000);
    queue_probe(OP_RECORD, 1'b1, 16'h8001);
    queue_probe(OP_RECORD, 1'b1, 16'h7FFE);
    queue_probe(OP_RECORD, 1'b0, 16'h5555);
    queue_probe(OP_RECORD, 1'b1, 16'hAAAA);
    queue_probe(OP_CLEAR, 1'b0, 16'h0000);

    // drain fully once before the random part
    hold_src = 1'b1;
    @(negedge clk);
    hold_src = 1'b0;
    wait (pending_probes.size() == 0);
    hold_src = 1'b1;
    wait (expected_snaps.size() == 0 && !s_tvalid);
    hold_src = 1'b0;

    // random: long runs that wrap the window, rare clears
    n = 0;
    while (n < 1100) begin
      int run;
      int mode;
      run = $urandom_range(20, 260);
      mode = $urandom_range(0, 3);
      for (int i = 0; i < run && n < 1100; i++) begin
        logic [15:0] lat;
        case (mode)
          0: lat = 16'($urandom_range(0, 65535));
          1: lat = 16'($urandom_range(0, 200));
          2: lat = 16'hFFFF - 16'($urandom_range(0, 15));
          default: lat = 16'($urandom_range(10, 50));
        endcase
        queue_probe(OP_RECORD, ($urandom_range(0, 9) < 8), lat);
        n++;
      end
      queue_probe(OP_CLEAR, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
      n++;
    end

    wait (pending_probes.size() == 0);
    @(negedge clk);
    wait (expected_snaps.size() == 0 && !s_tvalid);
    repeat (300) @(posedge clk);

    $display("covered %0d items (%0d clears) and %0d snapshots with window wraparound",
             items_sent, clears_sent, snaps_seen);
    if (mismatches == 0 && expected_snaps.size() == 0) begin
      $display("windowed_latency_statistics_tb passed");
    end else begin
      $display("%0d mismatches, %0d snapshots missing", mismatches, expected_snaps.size());
      $display("windowed_latency_statistics_tb failed");
    end
    $finish;
  end

endmodule
